// ===== design/nllp_pkg.sv =====
package nllp_pkg;

  localparam int unsigned MaxBufferBytesDef = 65536;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW = $clog2(FifoDepth);
  localparam int unsigned FifoCntW = $clog2(FifoDepth + 1);

  localparam logic [7:0] MsgTypeLogHi = 8'd4;
  localparam logic [7:0] MsgTypeLogLo = 8'd0;
  localparam logic [13:0] AttrPacketHdr = 14'd1;
  localparam logic [13:0] AttrMark = 14'd2;
  localparam logic [13:0] AttrTimestamp = 14'd3;
  localparam logic [13:0] AttrPayload = 14'd9;

  localparam logic RecPacket = 1'b0;
  localparam logic RecSummary = 1'b1;

  typedef enum logic [4:0] {
    PH_HDR   = 5'b00001,
    PH_WAIT  = 5'b00010,
    PH_GEN   = 5'b00100,
    PH_AHDR  = 5'b01000,
    PH_ADATA = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        record_kind;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [15:0] link_protocol;
    logic [31:0] packet_mark;
    logic [63:0] time_seconds;
    logic [63:0] time_microseconds;
    logic [15:0] packet_count;
    logic        walk_error;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [31:0] align4(input logic [31:0] v);
    logic [31:0] s;
    s = v + 32'd3;
    return {s[31:2], 2'b00};
  endfunction

endpackage

// ===== design/nllp_res_fifo.sv =====
module nllp_res_fifo
  import nllp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  push_t               push,
  input  logic                pop,
  output result_t             head,
  output logic [FifoCntW-1:0] count
);

  result_t               mem [FifoDepth];
  logic [FifoPtrW-1:0]   wp_r, rp_r;
  logic [FifoCntW-1:0]   cnt_r;
  logic [FifoPtrW-1:0]   wp1;

  assign wp1 = wp_r + FifoPtrW'(1);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wp_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wp1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + FifoPtrW'(push.count);
      rp_r  <= rp_r + FifoPtrW'(pop);
      cnt_r <= cnt_r + FifoCntW'(push.count) - FifoCntW'(pop);
    end
  end

  assign head  = mem[rp_r];
  assign count = cnt_r;

endmodule

// ===== design/netlink_log_record_parser_core.sv =====
// Byte-serial netlink log walker: takes one buffer byte per cycle with no gaps of its own.
// State for message headers, attributes and captured fields updates in the accepting cycle
// and any packet record and end-of-buffer summary are queued in a four-entry result fifo;
// a byte produces zero, one or two results. in_stall rises only when fewer than two fifo
// slots are free, so the rate is one byte per cycle while the output side keeps up.
module netlink_log_record_parser_core
  import nllp_pkg::*;
#(
  parameter int unsigned MAX_BUFFER_BYTES = MaxBufferBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic [16:0] in_buffer_length,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_kind,
  output logic [15:0] out_payload_offset,
  output logic [15:0] out_payload_length,
  output logic [15:0] out_link_protocol,
  output logic [31:0] out_packet_mark,
  output logic [63:0] out_time_seconds,
  output logic [63:0] out_time_microseconds,
  output logic [15:0] out_packet_count,
  output logic        out_walk_error,
  output logic        out_last_result
);

  localparam int unsigned PW = $clog2(MAX_BUFFER_BYTES + 1);
  localparam logic [31:0] MaxB = 32'(MAX_BUFFER_BYTES);

  logic [PW-1:0] pos_r, pos_nxt, ms_r, ms_nxt, rem_r, rem_nxt;
  logic [31:0]   ml_r, ml_nxt, ah_r, ah_nxt, mark_r, mark_nxt;
  logic [15:0]   mt_r, mt_nxt, idx_r, idx_nxt, hw_r, hw_nxt;
  logic [15:0]   poff_r, poff_nxt, plen_r, plen_nxt, cnt_r, cnt_nxt;
  logic [63:0]   sec_r, sec_nxt, usec_r, usec_nxt;
  logic          stop_r, stop_nxt;
  phase_t        ph_r, ph_nxt;

  logic                in_acc, out_acc;
  push_t               push;
  result_t             head;
  logic [FifoCntW-1:0] fcount;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = fcount > FifoCntW'(FifoDepth - 2);
  assign out_valid = fcount != '0;

  always_comb begin
    logic [31:0] lc, pos, ms, off, nl, a, dlen, i, rem32;
    logic [13:0] ty;
    logic        run_end, pkt, rec;
    result_t     r_rec, r_sum;
    pos_nxt = pos_r; ms_nxt = ms_r; rem_nxt = rem_r; ml_nxt = ml_r; ah_nxt = ah_r;
    mark_nxt = mark_r; mt_nxt = mt_r; idx_nxt = idx_r; hw_nxt = hw_r; poff_nxt = poff_r;
    plen_nxt = plen_r; cnt_nxt = cnt_r; sec_nxt = sec_r; usec_nxt = usec_r;
    stop_nxt = stop_r; ph_nxt = ph_r;
    lc = (32'(in_buffer_length) > MaxB) ? MaxB : 32'(in_buffer_length);
    pos = 32'(pos_r);
    ms = 32'(ms_r);
    off = pos - ms;
    nl = {16'd0, ah_r[15:0]};
    ty = ah_r[29:16];
    a = '0; dlen = '0; i = '0; rem32 = '0;
    run_end = 1'b0; pkt = 1'b0; rec = 1'b0;
    r_rec = '0; r_sum = '0;
    push = '0;
    if (in_acc) begin
      if (!stop_r && pos < lc) begin
        run_end = 1'b1;
        case (ph_r)
          PH_HDR: begin
            if (off == 32'd0 && lc - ms < 32'd16) begin
              stop_nxt = 1'b1;
              run_end = 1'b0;
            end else begin
              if (off < 32'd4) begin
                ml_nxt = ml_r | (32'(in_byte_value) << {off[1:0], 3'b000});
              end else if (off == 32'd4) begin
                mt_nxt = {8'd0, in_byte_value};
              end else if (off == 32'd5) begin
                mt_nxt = mt_r | {in_byte_value, 8'd0};
              end
              if (off == 32'd15) begin
                if (ml_nxt < 32'd16 || ml_nxt > lc - ms) begin
                  stop_nxt = 1'b1;
                  run_end = 1'b0;
                end else if (mt_nxt[15:8] == MsgTypeLogHi && mt_nxt[7:0] == MsgTypeLogLo
                             && ml_nxt > 32'd20) begin
                  ph_nxt = PH_GEN;
                  rem_nxt = PW'(ml_nxt - 32'd20);
                  hw_nxt = '0; mark_nxt = '0; sec_nxt = '0; usec_nxt = '0;
                  poff_nxt = '0; plen_nxt = '0;
                end else begin
                  ph_nxt = PH_WAIT;
                end
              end
            end
          end
          PH_GEN: begin
            if (off == 32'd19) begin
              ah_nxt = '0;
              idx_nxt = '0;
              ph_nxt = (32'(rem_r) < 32'd4) ? PH_WAIT : PH_AHDR;
            end
          end
          PH_AHDR: begin
            ah_nxt = ah_r | (32'(in_byte_value) << {idx_r[1:0], 3'b000});
            idx_nxt = idx_r + 16'd1;
            if (idx_nxt == 16'd4) begin
              nl = {16'd0, ah_nxt[15:0]};
              ty = ah_nxt[29:16];
              if (nl < 32'd4 || nl > 32'(rem_r)) begin
                ph_nxt = PH_WAIT;
              end else begin
                if (ty == AttrPayload && nl > 32'd4) begin
                  poff_nxt = 16'(pos + 32'd1);
                  plen_nxt = 16'(nl - 32'd4);
                end
                idx_nxt = '0;
                a = align4(nl);
                if (a == 32'd4) begin
                  if (a > 32'(rem_r)) begin
                    ph_nxt = PH_WAIT;
                  end else begin
                    rem32 = 32'(rem_r) - a;
                    rem_nxt = PW'(rem32);
                    ah_nxt = '0;
                    ph_nxt = (rem32 < 32'd4) ? PH_WAIT : PH_AHDR;
                  end
                end else begin
                  ph_nxt = PH_ADATA;
                end
              end
            end
          end
          PH_ADATA: begin
            dlen = nl - 32'd4;
            i = 32'(idx_r);
            if (i < dlen) begin
              if (ty == AttrPacketHdr && dlen >= 32'd4 && i < 32'd2) begin
                hw_nxt = {hw_r[7:0], in_byte_value};
              end else if (ty == AttrMark && dlen >= 32'd4 && i < 32'd4) begin
                mark_nxt = {mark_r[23:0], in_byte_value};
              end else if (ty == AttrTimestamp && dlen >= 32'd16 && i < 32'd8) begin
                sec_nxt = {sec_r[55:0], in_byte_value};
              end else if (ty == AttrTimestamp && dlen >= 32'd16 && i < 32'd16) begin
                usec_nxt = {usec_r[55:0], in_byte_value};
              end
            end
            idx_nxt = idx_r + 16'd1;
            a = align4(nl);
            if (32'(idx_nxt) >= a - 32'd4) begin
              if (a > 32'(rem_r)) begin
                ph_nxt = PH_WAIT;
              end else begin
                rem32 = 32'(rem_r) - a;
                rem_nxt = PW'(rem32);
                ah_nxt = '0;
                idx_nxt = '0;
                ph_nxt = (rem32 < 32'd4) ? PH_WAIT : PH_AHDR;
              end
            end
          end
          default: begin
          end
        endcase
        if (run_end && ph_nxt != PH_HDR) begin
          pkt = mt_nxt[15:8] == MsgTypeLogHi && mt_nxt[7:0] == MsgTypeLogLo
                && ml_nxt > 32'd20;
          if (pkt && {1'b0, pos} + 33'd1 == {1'b0, ms} + {1'b0, ml_nxt}) begin
            rec = plen_nxt != 16'd0;
            cnt_nxt = cnt_r + 16'd1;
            ph_nxt = PH_WAIT;
          end
          if ({1'b0, pos} + 33'd1 == {1'b0, ms} + {1'b0, align4(ml_nxt)}) begin
            ms_nxt = PW'(pos + 32'd1);
            ml_nxt = '0;
            mt_nxt = '0;
            ph_nxt = PH_HDR;
          end
        end
      end
      r_rec.record_kind = RecPacket;
      r_rec.payload_offset = poff_nxt;
      r_rec.payload_length = plen_nxt;
      r_rec.link_protocol = hw_nxt;
      r_rec.packet_mark = mark_nxt;
      r_rec.time_seconds = sec_nxt;
      r_rec.time_microseconds = usec_nxt;
      r_rec.last_result = !in_last_byte;
      r_sum.record_kind = RecSummary;
      r_sum.packet_count = cnt_nxt;
      r_sum.walk_error = lc < 32'd16;
      r_sum.last_result = 1'b1;
      if (rec) begin
        push.first = r_rec;
        push.second = r_sum;
        push.count = in_last_byte ? 2'd2 : 2'd1;
      end else if (in_last_byte) begin
        push.first = r_sum;
        push.count = 2'd1;
      end
      pos_nxt = (pos < MaxB) ? PW'(pos + 32'd1) : pos_r;
      if (in_last_byte) begin
        pos_nxt = '0; ms_nxt = '0; rem_nxt = '0; ml_nxt = '0; ah_nxt = '0;
        mark_nxt = '0; mt_nxt = '0; idx_nxt = '0; hw_nxt = '0; poff_nxt = '0;
        plen_nxt = '0; cnt_nxt = '0; sec_nxt = '0; usec_nxt = '0;
        stop_nxt = 1'b0; ph_nxt = PH_HDR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; ms_r <= '0; rem_r <= '0; ml_r <= '0; ah_r <= '0;
      mark_r <= '0; mt_r <= '0; idx_r <= '0; hw_r <= '0; poff_r <= '0;
      plen_r <= '0; cnt_r <= '0; sec_r <= '0; usec_r <= '0;
      stop_r <= 1'b0; ph_r <= PH_HDR;
    end else begin
      pos_r <= pos_nxt; ms_r <= ms_nxt; rem_r <= rem_nxt; ml_r <= ml_nxt; ah_r <= ah_nxt;
      mark_r <= mark_nxt; mt_r <= mt_nxt; idx_r <= idx_nxt; hw_r <= hw_nxt;
      poff_r <= poff_nxt; plen_r <= plen_nxt; cnt_r <= cnt_nxt; sec_r <= sec_nxt;
      usec_r <= usec_nxt; stop_r <= stop_nxt; ph_r <= ph_nxt;
    end
  end

  nllp_res_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_acc),
    .head  (head),
    .count (fcount)
  );

  assign out_record_kind       = head.record_kind;
  assign out_payload_offset    = head.payload_offset;
  assign out_payload_length    = head.payload_length;
  assign out_link_protocol     = head.link_protocol;
  assign out_packet_mark       = head.packet_mark;
  assign out_time_seconds      = head.time_seconds;
  assign out_time_microseconds = head.time_microseconds;
  assign out_packet_count      = head.packet_count;
  assign out_walk_error        = head.walk_error;
  assign out_last_result       = head.last_result;

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcount <= FifoCntW'(FifoDepth))
    else $error("result fifo overflow");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_byte |=> pos_r == '0 && cnt_r == '0 && !stop_r)
    else $error("state not cleared after buffer end");

  a_last_summary: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_byte |-> push.count != 2'd0)
    else $error("no summary pushed on last byte");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import nllp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxBytes = MaxBufferBytesDef;
  localparam int WatchdogLimit = 20000;

  localparam logic [2:0] StHdr = 3'd0;
  localparam logic [2:0] StWait = 3'd1;
  localparam logic [2:0] StGen = 3'd2;
  localparam logic [2:0] StAhdr = 3'd3;
  localparam logic [2:0] StAdata = 3'd4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte_value = '0;
  logic [16:0] in_buffer_length = '0;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_record_kind;
  logic [15:0] out_payload_offset;
  logic [15:0] out_payload_length;
  logic [15:0] out_link_protocol;
  logic [31:0] out_packet_mark;
  logic [63:0] out_time_seconds;
  logic [63:0] out_time_microseconds;
  logic [15:0] out_packet_count;
  logic out_walk_error;
  logic out_last_result;

  always #2 clk = ~clk;

  netlink_log_record_parser_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_byte_value(in_byte_value), .in_buffer_length(in_buffer_length),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_record_kind(out_record_kind), .out_payload_offset(out_payload_offset),
    .out_payload_length(out_payload_length), .out_link_protocol(out_link_protocol),
    .out_packet_mark(out_packet_mark), .out_time_seconds(out_time_seconds),
    .out_time_microseconds(out_time_microseconds),
    .out_packet_count(out_packet_count), .out_walk_error(out_walk_error),
    .out_last_result(out_last_result)
  );

  // walker state
  logic [16:0] pos_q, msg_start_q;
  logic [31:0] msg_len_q;
  logic [15:0] msg_type_q;
  logic [2:0] phase_q;
  logic [31:0] attr_rem_q;
  logic [31:0] attr_hdr_q;
  logic [31:0] attr_idx_q;
  logic [15:0] hw_q;
  logic [31:0] mark_q;
  logic [63:0] sec_q, usec_q;
  logic [15:0] poff_q, plen_q, count_q;
  logic stopped_q;

  result_t expected_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  function automatic logic [31:0] round4(logic [31:0] v);
    return (v + 32'd3) & ~32'd3;
  endfunction

  task automatic walker_reset();
    pos_q = '0; msg_start_q = '0; msg_len_q = '0; msg_type_q = '0; phase_q = StHdr;
    attr_rem_q = '0; attr_hdr_q = '0; attr_idx_q = '0; hw_q = '0; mark_q = '0;
    sec_q = '0; usec_q = '0; poff_q = '0; plen_q = '0; count_q = '0; stopped_q = 0;
  endtask

  function automatic bit is_log_msg();
    return msg_type_q[15:8] == MsgTypeLogHi && msg_type_q[7:0] == MsgTypeLogLo &&
           msg_len_q > 32'd20;
  endfunction

  task automatic start_attr();
    attr_hdr_q = '0;
    attr_idx_q = '0;
    phase_q = (attr_rem_q < 4) ? StWait : StAhdr;
  endtask

  task automatic next_attr();
    logic [31:0] a;
    a = round4({16'd0, attr_hdr_q[15:0]});
    if (a > attr_rem_q) begin
      phase_q = StWait;
    end else begin
      attr_rem_q = attr_rem_q - a;
      start_attr();
    end
  endtask

  task automatic push_result(logic kind, logic [15:0] off, logic [15:0] len, logic [15:0] hw,
                             logic [31:0] mk, logic [63:0] s, logic [63:0] us,
                             logic [15:0] cnt, logic err);
    result_t r;
    r = '{kind, off, len, hw, mk, s, us, cnt, err, 1'b0};
    expected_results.push_back(r);
  endtask

  task automatic walk_byte(logic [7:0] b, logic [31:0] len_l, ref int n);
    logic [31:0] p, off, nl, ty, dlen, i;
    p = 32'(pos_q);
    off = p - 32'(msg_start_q);
    nl = 32'(attr_hdr_q[15:0]);
    ty = 32'(attr_hdr_q[29:16]);
    case (phase_q)
      StHdr: begin
        if (off == 0 && len_l - 32'(msg_start_q) < 16) begin
          stopped_q = 1;
          return;
        end
        if (off < 4) msg_len_q = msg_len_q | (32'(b) << (8 * off));
        else if (off == 4) msg_type_q = 16'(b);
        else if (off == 5) msg_type_q[15:8] = b;
        if (off == 15) begin
          if (msg_len_q < 16 || msg_len_q > len_l - 32'(msg_start_q)) begin
            stopped_q = 1;
            return;
          end
          if (is_log_msg()) begin
            phase_q = StGen;
            attr_rem_q = msg_len_q - 32'd20;
            hw_q = '0; mark_q = '0; sec_q = '0; usec_q = '0; poff_q = '0; plen_q = '0;
          end else begin
            phase_q = StWait;
          end
        end
      end
      StGen: if (off == 19) start_attr();
      StAhdr: begin
        attr_hdr_q = attr_hdr_q | (32'(b) << (8 * attr_idx_q[1:0]));
        attr_idx_q++;
        if (attr_idx_q == 4) begin
          nl = 32'(attr_hdr_q[15:0]);
          ty = 32'(attr_hdr_q[29:16]);
          if (nl < 4 || nl > attr_rem_q) begin
            phase_q = StWait;
          end else begin
            if (ty == AttrPayload && nl > 4) begin
              poff_q = 16'(p + 1);
              plen_q = 16'(nl - 4);
            end
            attr_idx_q = 0;
            if (round4(nl) == 4) next_attr();
            else phase_q = StAdata;
          end
        end
      end
      StAdata: begin
        dlen = nl - 4;
        i = attr_idx_q;
        if (i < dlen) begin
          if (ty == AttrPacketHdr && dlen >= 4 && i < 2) hw_q = {hw_q[7:0], b};
          else if (ty == AttrMark && dlen >= 4 && i < 4) mark_q = {mark_q[23:0], b};
          else if (ty == AttrTimestamp && dlen >= 16 && i < 8) sec_q = {sec_q[55:0], b};
          else if (ty == AttrTimestamp && dlen >= 16 && i < 16) usec_q = {usec_q[55:0], b};
        end
        attr_idx_q++;
        if (attr_idx_q >= round4(nl) - 4) next_attr();
      end
      default: ;
    endcase
    if (phase_q != StHdr) begin
      if (is_log_msg() && p + 1 == 32'(msg_start_q) + msg_len_q) begin
        if (plen_q > 0) begin
          push_result(RecPacket, poff_q, plen_q, hw_q, mark_q, sec_q, usec_q, '0, 1'b0);
          n++;
        end
        count_q++;
        phase_q = StWait;
      end
      if (p + 1 == 32'(msg_start_q) + round4(msg_len_q)) begin
        msg_start_q = 17'(p + 1);
        msg_len_q = '0;
        msg_type_q = '0;
        phase_q = StHdr;
      end
    end
  endtask

  task automatic predict_byte(logic [7:0] b, logic [16:0] len_in, logic last);
    logic [31:0] len_l;
    int n;
    n = 0;
    len_l = (32'(len_in) > MaxBytes) ? MaxBytes : 32'(len_in);
    if (!stopped_q && 32'(pos_q) < len_l) walk_byte(b, len_l, n);
    if (pos_q < MaxBytes) pos_q++;
    if (last) begin
      push_result(RecSummary, '0, '0, '0, '0, '0, '0, count_q, len_l < 16);
      n++;
      walker_reset();
    end
    if (n > 0) expected_results[$].last_result = 1'b1;
  endtask

  // byte stream of pending transactions
  typedef struct {
    logic [7:0] b;
    logic [16:0] len;
    logic last;
  } byte_item_t;
  byte_item_t byte_stream[$];

  task automatic add_byte(logic [7:0] b, logic [16:0] len, logic last);
    byte_item_t t;
    t.b = b; t.len = len; t.last = last;
    byte_stream.push_back(t);
  endtask

  // a buffer image assembled from messages
  logic [7:0] buf_img[$];

  task automatic put_le(logic [31:0] v, int nbytes);
    for (int k = 0; k < nbytes; k++) buf_img.push_back(v[8*k +: 8]);
  endtask

  task automatic put_be(logic [63:0] v, int nbytes);
    for (int k = nbytes - 1; k >= 0; k--) buf_img.push_back(v[8*k +: 8]);
  endtask

  task automatic pad4();
    while (buf_img.size() % 4 != 0) buf_img.push_back(8'($urandom));
  endtask

  task automatic put_attr(logic [15:0] ty, int dlen, bit junk_type_bits);
    logic [15:0] t;
    t = junk_type_bits ? (ty | (16'($urandom_range(0, 3)) << 14)) : ty;
    put_le(dlen + 4, 2);
    put_le(t, 2);
    for (int k = 0; k < dlen; k++) buf_img.push_back(8'($urandom));
    pad4();
  endtask

  task automatic put_log_msg(bit broken);
    int start, nattr, ty, dlen;
    logic [31:0] mlen;
    start = buf_img.size();
    put_le(0, 4);
    put_le(16'h0400, 2);
    for (int k = 0; k < 14; k++) buf_img.push_back(8'($urandom));
    nattr = $urandom_range(0, 5);
    for (int k = 0; k < nattr; k++) begin
      case ($urandom_range(0, 5))
        0: begin ty = AttrPacketHdr; dlen = $urandom_range(0, 6); end
        1: begin ty = AttrMark; dlen = $urandom_range(3, 4); end
        2: begin ty = AttrTimestamp; dlen = $urandom_range(14, 17); end
        3, 4: begin ty = AttrPayload; dlen = $urandom_range(0, 12); end
        default: begin ty = $urandom_range(0, 15); dlen = $urandom_range(0, 6); end
      endcase
      put_attr(ty, dlen, $urandom_range(0, 3) == 0);
    end
    if (broken) begin
      put_le($urandom_range(0, 40), 2);
      put_le($urandom, 2);
      for (int k = 0; k < $urandom_range(0, 6); k++) buf_img.push_back(8'($urandom));
    end
    mlen = buf_img.size() - start;
    if ($urandom_range(0, 5) == 0 && mlen > 21) mlen = mlen - $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) buf_img[start + k] = mlen[8*k +: 8];
  endtask

  task automatic put_other_msg();
    int start, dl;
    logic [31:0] mlen;
    start = buf_img.size();
    dl = $urandom_range(0, 10);
    put_le(16 + dl, 4);
    put_le($urandom_range(0, 1) ? $urandom_range(2, 3) : $urandom, 2);
    for (int k = 0; k < 10 + dl; k++) buf_img.push_back(8'($urandom));
    pad4();
    mlen = 16 + dl;
    for (int k = 0; k < 4; k++) buf_img[start + k] = mlen[8*k +: 8];
  endtask

  task automatic emit_buffer(int len_field, int stop_at);
    for (int k = 0; k < stop_at; k++)
      add_byte(k < buf_img.size() ? buf_img[k] : 8'($urandom), 17'(len_field),
               k == stop_at - 1);
  endtask

  task automatic random_buffer();
    int nmsg, len, stop_at, mode;
    buf_img.delete();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      len = $urandom_range(0, 20);
      for (int k = 0; k < len; k++) buf_img.push_back(8'($urandom));
      stop_at = (len == 0) ? 1 : len;
      emit_buffer($urandom_range(0, 1) ? len : $urandom, stop_at);
      return;
    end
    nmsg = $urandom_range(1, 4);
    for (int m = 0; m < nmsg; m++) begin
      if ($urandom_range(0, 3) == 0) put_other_msg();
      else put_log_msg($urandom_range(0, 6) == 0);
    end
    len = buf_img.size();
    stop_at = len;
    case (mode)
      1: stop_at = $urandom_range(1, len);
      2: len = len - $urandom_range(0, 8);
      3: stop_at = len + $urandom_range(1, 6);
      4: len = 17'h1ffff - $urandom_range(0, 3);
      default: ;
    endcase
    if (stop_at < 1) stop_at = 1;
    emit_buffer(len, stop_at);
  endtask

  // directed table: byte, length, last, expected record typed where obvious
  typedef struct {
    logic [7:0] b;
    logic [16:0] len;
    logic last;
    bit has_fixed;
    result_t fixed;
  } table_row_t;
  table_row_t directed_rows[$];

  task automatic add_row(logic [7:0] b, logic [16:0] len, logic last, bit has_fixed,
                         result_t r);
    table_row_t t;
    t.b = b; t.len = len; t.last = last; t.has_fixed = has_fixed; t.fixed = r;
    directed_rows.push_back(t);
  endtask

  // driver
  initial begin
    int sent, target, gap;
    result_t summary_err, summary_ok;
    summary_err = '{RecSummary, 16'd0, 16'd0, 16'd0, 32'd0, 64'd0, 64'd0, 16'd0, 1'b1, 1'b1};
    summary_ok = summary_err;
    summary_ok.walk_error = 1'b0;
    walker_reset();
    add_row(8'hff, 17'd0, 1'b1, 1, summary_err);
    add_row(8'h00, 17'h1ffff, 1'b1, 1, summary_ok);
    add_row(8'hff, 17'd15, 1'b1, 1, summary_err);
    add_row(8'h00, 17'd16, 1'b1, 1, summary_ok);
    // one log message: header, generic header, payload attribute of one byte
    begin
      logic [7:0] m[$];
      m = '{8'd28, 8'd0, 8'd0, 8'd0, 8'h00, 8'h04, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
            8'd0, 8'd0, 8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd5, 8'd0, 8'h09, 8'hc0,
            8'hab, 8'd0, 8'd0, 8'd0};
      foreach (m[k]) add_row(m[k], 17'd28, k == m.size() - 1, 0, summary_ok);
    end
    @(posedge clk);
    @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (directed_rows[k]) begin
      add_byte(directed_rows[k].b, directed_rows[k].len, directed_rows[k].last);
    end
    sent = 0;
    target = 1650;
    while (byte_stream.size() > 0 || sent < target + directed_rows.size()) begin
      byte_item_t t;
      if (byte_stream.size() == 0) random_buffer();
      t = byte_stream.pop_front();
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_byte_value <= t.b;
      in_buffer_length <= t.len;
      in_last_byte <= t.last;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (sent < directed_rows.size() && directed_rows[sent].has_fixed) begin
        predict_byte(t.b, t.len, t.last);
        expected_results[$] = directed_rows[sent].fixed;
      end else begin
        predict_byte(t.b, t.len, t.last);
      end
      sent++;
      @(negedge clk);
    end
    in_valid <= 1'b0;
    while (expected_results.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && !timed_out) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // receiver stall pattern
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      out_stall <= (gap > 0);
      repeat (gap > 0 ? gap : $urandom_range(1, 8)) @(negedge clk);
    end
  end

  // checker and watchdog
  always @(posedge clk) begin
    result_t got, exp_r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        timed_out = 1;
        $display("testbench NOT OK");
        $finish;
      end
      if (out_valid && !out_stall) begin
        got = '{out_record_kind, out_payload_offset, out_payload_length, out_link_protocol,
                out_packet_mark, out_time_seconds, out_time_microseconds, out_packet_count,
                out_walk_error, out_last_result};
        #0;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected kind %0d off %0d len %0d hw %h mark %h s %h us %h cnt %0d err %0d last %0d",
                       exp_r.record_kind, exp_r.payload_offset, exp_r.payload_length,
                       exp_r.link_protocol, exp_r.packet_mark, exp_r.time_seconds,
                       exp_r.time_microseconds, exp_r.packet_count, exp_r.walk_error,
                       exp_r.last_result);
              $display("  actual   kind %0d off %0d len %0d hw %h mark %h s %h us %h cnt %0d err %0d last %0d",
                       got.record_kind, got.payload_offset, got.payload_length,
                       got.link_protocol, got.packet_mark, got.time_seconds,
                       got.time_microseconds, got.packet_count, got.walk_error,
                       got.last_result);
            end
          end
        end
      end
    end
  end

endmodule

// ===== files.f =====
design/nllp_pkg.sv
design/nllp_res_fifo.sv
design/netlink_log_record_parser_core.sv
tb/sv/testbench.sv
